// ===== src/rx_ring_in_order_reclaim_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Receive ring reclaim unit: assertion macros
// Shared concurrent assertion forms for the reclaim unit's RTL.
// ----------------------------------------------------------------------------
`ifndef RX_RING_IN_ORDER_RECLAIM_UNIT_MACROS_SVH
`define RX_RING_IN_ORDER_RECLAIM_UNIT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define RXRR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define RXRR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rxrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive ring reclaim unit: package
// Field widths, command codes and the control structs shared by the modules.
// ----------------------------------------------------------------------------
package rxrr_pkg;

    // Command codes carried in s_tuser.
    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Input field widths.
    localparam int LEN_W = 12;
    localparam int REL_W = 9;

    // Output field widths.
    localparam int OIDX_W = 8;
    localparam int OCNT_W = 9;

    // Packed stream widths.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // Control from the top level to the drain sequencer.
    typedef struct packed {
        logic start;    // an item was accepted this cycle
        logic do_mark;  // the item marks a slot ready and runs the walk
        logic out_free; // the output register can take a result this cycle
    } drain_ctrl_t;

    // Status from the drain sequencer back to the top level.
    typedef struct packed {
        logic idle;     // ready for a new item
        logic done;     // walk result valid this cycle
    } drain_stat_t;

endpackage

// ===== src/rxrr_mark_mem.sv =====
// ----------------------------------------------------------------------------
// Receive ring reclaim unit: ready-mark memory
// One bit per ring slot, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rxrr_mark_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rxrr_drain_seq.sv =====
// ----------------------------------------------------------------------------
// Receive ring reclaim unit: drain sequencer
// Clears the mark memory after reset, marks a slot ready and walks the
// reclaim head over consecutive ready slots, one slot per cycle.
// ----------------------------------------------------------------------------
`include "rx_ring_in_order_reclaim_unit_macros.svh"

module rxrr_drain_seq
    import rxrr_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  drain_ctrl_t      ctrl,
    input  logic [IDX_W-1:0] req_slot,
    output drain_stat_t      stat,
    output logic [CNT_W-1:0] walk_count,
    output logic [IDX_W-1:0] walk_last
);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MARK  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             hit_reg, hit_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_rdata;

    logic             head_ready;
    logic [IDX_W-1:0] head_inc;

    rxrr_mark_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_mark_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // The mark written in the mark cycle is forwarded when it hits the head.
    assign head_ready = mem_rdata | hit_reg;
    assign head_inc   = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    // Next-state and memory port control.
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        head_next  = head_reg;
        last_next  = last_reg;
        count_next = count_reg;
        hit_next   = hit_reg;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = head_reg;

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (slot_reg == LAST_SLOT) begin
                    slot_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (ctrl.start) begin
                    slot_next  = req_slot;
                    count_next = '0;
                    last_next  = '0;
                    state_next = ctrl.do_mark ? ST_MARK : ST_DONE;
                end
            end
            ST_MARK: begin
                mem_we     = 1'b1;
                mem_wdata  = 1'b1;
                mem_re     = 1'b1;
                hit_next   = (slot_reg == head_reg);
                state_next = ST_WALK;
            end
            ST_WALK: begin
                hit_next = 1'b0;
                if (head_ready && (count_reg != FULL_CNT)) begin
                    // Reclaim the head slot and fetch the one after it.
                    mem_we     = 1'b1;
                    mem_waddr  = head_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = head_inc;
                    last_next  = head_reg;
                    head_next  = head_inc;
                    count_next = count_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ctrl.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            slot_reg  <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
        end
    end

    // Last reclaimed slot.
    always_ff @(posedge aclk) begin
        last_reg <= last_next;
    end

    assign stat.idle  = (state_reg == ST_IDLE);
    assign stat.done  = (state_reg == ST_DONE) && ctrl.out_free;
    assign walk_count = count_reg;
    assign walk_last  = last_reg;

    // A result is only handed over when the output register can take it.
    `RXRR_ASSERT_SAME(a_done_free, aclk, aresetn, stat.done, ctrl.out_free, "done while output busy")
    // Items only start while the sequencer is idle.
    `RXRR_ASSERT_SAME(a_start_idle, aclk, aresetn, ctrl.start, state_reg == ST_IDLE, "start while busy")
    // During the walk the write and the prefetch never hit the same slot.
    `RXRR_ASSERT_SAME(a_walk_ports, aclk, aresetn, (state_reg == ST_WALK) && mem_we && mem_re, mem_waddr != mem_raddr, "walk port collision")
    // A walk that has reclaimed the whole ring stops.
    `RXRR_ASSERT_NEXT(a_walk_bound, aclk, aresetn, (state_reg == ST_WALK) && (count_reg == FULL_CNT), state_reg == ST_DONE, "walk ran past ring depth")

endmodule

// ===== src/rx_ring_in_order_reclaim_unit.sv =====
// An item with no slot to mark goes from the idle state straight to the done state;
// a marking item passes through the mark, walk and done states in that order.
// One item at a time; the walk visits one slot per cycle, and the next item is
// taken only once the result has been handed to the output register.
// Reset: synchronous, active low; a clearing pass then zeroes the mark memory,
// during which s_tready stays low.
// ----------------------------------------------------------------------------
// Receive ring in-order reclaim unit
// Hands received slots to a consumer, takes releases in any order and returns
// slots to the device strictly in ring order, reporting the new ring tail.
// ----------------------------------------------------------------------------
module rx_ring_in_order_reclaim_unit
    import rxrr_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [11:0] frame_length, [12] consumer_accepted, [21:13] release_index
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] delivered, [8:1] delivered_index, [9] rejected, [10] tail_written,
    // [18:11] tail_value, [27:19] reclaimed_count
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

    logic [LEN_W-1:0] in_len;
    logic             in_kept;
    logic [REL_W-1:0] in_rel;
    logic             accept;
    logic             given;
    logic             rel_bad;

    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic             pend_delivered_reg;
    logic [IDX_W-1:0] pend_index_reg;
    logic             pend_rejected_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    drain_ctrl_t      ctrl;
    drain_stat_t      stat;
    logic [IDX_W-1:0] req_slot;
    logic [CNT_W-1:0] walk_count;
    logic [IDX_W-1:0] walk_last;
    logic             tail_written;
    logic [IDX_W-1:0] tail_slot;

    // Input field unpacking and item decode.
    assign in_len  = s_tdata[LEN_W-1:0];
    assign in_kept = s_tdata[LEN_W];
    assign in_rel  = s_tdata[LEN_W+REL_W:LEN_W+1];
    assign accept  = s_tvalid && s_tready;
    assign given   = (in_len != '0) && in_kept;
    assign rel_bad = 32'(in_rel) >= 32'(RING_DEPTH);
    assign req_slot = (s_tuser == CMD_RECEIVE) ? cursor_reg : IDX_W'(in_rel);

    assign ctrl.start    = accept;
    assign ctrl.do_mark  = (s_tuser == CMD_RECEIVE) ? !given : !rel_bad;
    assign ctrl.out_free = !m_tvalid_reg || m_tready;
    assign s_tready      = stat.idle;

    rxrr_drain_seq #(
        .DEPTH (RING_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_drain_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .req_slot   (req_slot),
        .stat       (stat),
        .walk_count (walk_count),
        .walk_last  (walk_last)
    );

    // Receive cursor advances on every receive item.
    always_comb begin
        cursor_next = cursor_reg;
        if (accept && (s_tuser == CMD_RECEIVE)) begin
            cursor_next = (cursor_reg == LAST_SLOT) ? '0 : cursor_reg + 1'b1;
        end
    end

    // Output valid: set by a finished item, cleared when taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (stat.done) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cursor_reg   <= cursor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Fields known at acceptance, held until the walk is over.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_delivered_reg <= (s_tuser == CMD_RECEIVE) && given;
            pend_index_reg     <= (s_tuser == CMD_RECEIVE) ? cursor_reg : '0;
            pend_rejected_reg  <= (s_tuser == CMD_RELEASE) && rel_bad;
        end
    end

    // Result packing into the output register.
    assign tail_written = (walk_count != '0);
    assign tail_slot    = tail_written ? walk_last : '0;

    always_ff @(posedge aclk) begin
        if (stat.done) begin
            m_tdata_reg <= {4'b0000,
                            OCNT_W'(walk_count),
                            OIDX_W'(tail_slot),
                            tail_written,
                            pend_rejected_reg,
                            OIDX_W'(pend_index_reg),
                            pend_delivered_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
